// File: design/hvd_pkg.sv
`timescale 1ns / 1ps
package hvd_pkg;

    localparam int NUM_ST     = 16;
    localparam int NUM_SYM    = 32;
    localparam int MAX_LEN    = 1024;
    localparam int LOG_W      = 24;
    localparam int SCORE_W    = 40;
    localparam int ST_W       = $clog2(NUM_ST);
    localparam int SYM_W      = $clog2(NUM_SYM);
    localparam int POS_W      = $clog2(MAX_LEN);
    localparam int LEN_W      = POS_W + 1;
    localparam int NST_W      = 5;
    localparam int NSYM_W     = 6;

    localparam logic [2:0] FUNC_START = 3'd0;
    localparam logic [2:0] FUNC_TRANS = 3'd1;
    localparam logic [2:0] FUNC_EMIT  = 3'd2;
    localparam logic [2:0] FUNC_OBS   = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_PATH = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG = 2'd2;
    localparam logic [1:0] STAT_RANGE   = 2'd3;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_PATH    = 1'b1;

    localparam logic REG_NUM_STATES  = 1'b0;
    localparam logic REG_NUM_SYMBOLS = 1'b1;

    typedef logic signed [SCORE_W-1:0] score_val_t;
    typedef logic signed [LOG_W-1:0]   log_val_t;

    typedef struct packed {
        logic       imp;
        score_val_t val;
    } score_t;

    typedef struct packed {
        logic       imp;
        log_val_t   val;
    } log_entry_t;

    typedef struct packed {
        logic            imp;
        score_val_t      val;
        logic [ST_W-1:0] idx;
    } carry_t;

    typedef struct packed {
        logic             vld;
        logic [2:0]       func;
        logic [ST_W-1:0]  from_state;
        logic [ST_W-1:0]  to_state;
        logic [SYM_W-1:0] symbol;
        log_entry_t       entry;
    } tbl_wr_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             finish;
        logic             clear;
        logic             t_zero;
        logic             sym_ok;
        logic [NST_W-1:0] num_st;
        logic [SYM_W-1:0] symbol;
    } cell_ctl_t;

    function automatic score_val_t sat_add(score_val_t a, score_val_t b);
        logic signed [SCORE_W:0] s;
        s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (s[SCORE_W] != s[SCORE_W-1])
            return s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
        return s[SCORE_W-1:0];
    endfunction

    function automatic score_val_t log_ext(log_val_t v);
        return {{(SCORE_W-LOG_W){v[LOG_W-1]}}, v};
    endfunction

endpackage

// File: design/hvd_if.sv
`timescale 1ns / 1ps
interface hvd_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                func;
    logic [hvd_pkg::ST_W-1:0]  from_state;
    logic [hvd_pkg::ST_W-1:0]  to_state;
    logic [hvd_pkg::SYM_W-1:0] symbol;
    logic signed [hvd_pkg::LOG_W-1:0] log_value;
    logic                      impossible;
    logic                      last;
    logic [hvd_pkg::POS_W-1:0] position;

    modport source (output valid, func, from_state, to_state, symbol, log_value,
                    impossible, last, position, input ready);
    modport sink   (input valid, func, from_state, to_state, symbol, log_value,
                    impossible, last, position, output ready);
endinterface

interface hvd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [hvd_pkg::ST_W-1:0]    state_index;
    logic signed [hvd_pkg::SCORE_W-1:0] final_score;
    logic [hvd_pkg::LEN_W-1:0]   path_length;
    logic [1:0]                  status;

    modport source (output valid, kind, state_index, final_score, path_length, status,
                    input ready);
    modport sink   (input valid, kind, state_index, final_score, path_length, status,
                    output ready);
endinterface

// File: design/hvd_acs_cell.sv
`timescale 1ns / 1ps
module hvd_acs_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [hvd_pkg::ST_W-1:0]   cell_id,
    input  hvd_pkg::tbl_wr_t           wr,
    input  hvd_pkg::cell_ctl_t         ctl,
    input  hvd_pkg::carry_t            carry_in,
    output hvd_pkg::carry_t            carry_out,
    output hvd_pkg::score_t            score,
    output logic [hvd_pkg::ST_W:0]     back_ptr
);
    hvd_pkg::log_entry_t start_reg;
    hvd_pkg::log_entry_t trans_col [hvd_pkg::NUM_ST];
    hvd_pkg::log_entry_t emit_row [hvd_pkg::NUM_SYM];

    hvd_pkg::score_t      score_reg;
    hvd_pkg::carry_t      carry_reg;
    hvd_pkg::score_val_t  cand_reg;
    logic                 cand_ok_reg;
    logic                 cand_vld_reg;
    logic [hvd_pkg::ST_W-1:0] cand_idx_reg;
    hvd_pkg::score_val_t  best_reg;
    logic                 best_ok_reg;
    logic [hvd_pkg::ST_W-1:0] bp_reg;

    hvd_pkg::log_entry_t  tr;
    hvd_pkg::log_entry_t  em;
    logic                 active;
    logic                 take;
    hvd_pkg::score_t      result;

    assign tr     = trans_col[carry_reg.idx];
    assign em     = emit_row[ctl.symbol];
    assign active = {1'b0, cell_id} < ctl.num_st;
    assign take   = cand_vld_reg && cand_ok_reg
                    && (!best_ok_reg || cand_reg > best_reg
                        || (cand_reg == best_reg && cand_idx_reg < bp_reg));

    always_comb
    begin
        result.imp = 1'b1;
        result.val = '0;
        if (active && ctl.sym_ok && !em.imp)
        begin
            if (ctl.t_zero)
            begin
                if (!start_reg.imp)
                begin
                    result.imp = 1'b0;
                    result.val = hvd_pkg::sat_add(hvd_pkg::log_ext(start_reg.val),
                                                  hvd_pkg::log_ext(em.val));
                end
            end
            else if (best_ok_reg)
            begin
                result.imp = 1'b0;
                result.val = hvd_pkg::sat_add(best_reg, hvd_pkg::log_ext(em.val));
            end
        end
    end

    // tables: each cell keeps only its own column of transitions and row of emissions
    always_ff @(posedge clk)
    begin
        if (wr.vld)
        begin
            if (wr.func == hvd_pkg::FUNC_START && wr.from_state == cell_id)
                start_reg <= wr.entry;
            if (wr.func == hvd_pkg::FUNC_TRANS && wr.to_state == cell_id)
                trans_col[wr.from_state] <= wr.entry;
            if (wr.func == hvd_pkg::FUNC_EMIT && wr.from_state == cell_id)
                emit_row[wr.symbol] <= wr.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg.imp <= 1'b1;
            score_reg.val <= '0;
            cand_vld_reg  <= 1'b0;
            best_ok_reg   <= 1'b0;
        end
        else
        begin
            cand_vld_reg <= ctl.step;
            if (ctl.load)
                best_ok_reg <= 1'b0;
            else if (take)
                best_ok_reg <= 1'b1;
            if (ctl.clear)
                score_reg.imp <= 1'b1;
            else if (ctl.finish)
                score_reg.imp <= result.imp;
            if (ctl.finish)
                score_reg.val <= result.val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            carry_reg <= '{imp: score_reg.imp, val: score_reg.val, idx: cell_id};
        else if (ctl.step)
            carry_reg <= carry_in;
        // add stage: candidate from the predecessor passing by
        cand_reg     <= hvd_pkg::sat_add(carry_reg.val, hvd_pkg::log_ext(tr.val));
        cand_ok_reg  <= !carry_reg.imp && !tr.imp && ({1'b0, carry_reg.idx} < ctl.num_st);
        cand_idx_reg <= carry_reg.idx;
        // compare-select stage
        if (take)
        begin
            best_reg <= cand_reg;
            bp_reg   <= cand_idx_reg;
        end
    end

    assign carry_out = carry_reg;
    assign score     = score_reg;
    assign back_ptr  = result.imp ? '0 : {1'b1, bp_reg};

endmodule

// File: design/hmm_viterbi_decoder.sv
`timescale 1ns / 1ps
// Log-domain HMM Viterbi decoder.
// Input channel (in_ch): each transaction carries one command in func. Start,
// transition and emission writes load the model. An observation runs a ring
// of 16 add-compare-select cells: the previous scores circulate cell to cell,
// so every cell sees every predecessor. The observation marked last then scans
// the final scores and traces the path back from the back-pointer memory,
// alternating a row read with a pointer step, before the summary transaction
// appears. A path read goes through the registered path memory read port.
// Output channel (out_ch): at most one result per input transaction, held in an
// output register until taken; no new input is taken while it waits.
// Config (APB): num_states at 0x0, num_symbols at 0x4; write only while idle.
// Reset clears the scores to impossible, the time counter and the path-ready
// flag, and restores the config registers to 16 and 32. Tables and memories
// hold garbage until written.
module hmm_viterbi_decoder (
    input  logic               clk,
    input  logic               rst_n,
    hvd_in_if.sink             in_ch,
    hvd_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_FIN   = 4'd3;
    localparam logic [3:0] ST_BEST  = 4'd4;
    localparam logic [3:0] ST_TB    = 4'd5;
    localparam logic [3:0] ST_TBSEL = 4'd6;
    localparam logic [3:0] ST_RD    = 4'd7;

    localparam int NS     = hvd_pkg::NUM_ST;
    localparam int ST_W   = hvd_pkg::ST_W;
    localparam int LEN_W  = hvd_pkg::LEN_W;
    localparam int POS_W  = hvd_pkg::POS_W;

    logic [3:0]                  state_reg;
    logic [ST_W:0]               cnt_reg;
    logic [hvd_pkg::NST_W-1:0]   nst_reg;
    logic [hvd_pkg::NSYM_W-1:0]  nsym_reg;
    logic [LEN_W-1:0]            time_reg;
    logic                        path_ready_reg;
    logic [LEN_W-1:0]            stored_len_reg;
    logic [hvd_pkg::SYM_W-1:0]   sym_reg;
    logic                        last_reg;
    logic                        found_reg;
    hvd_pkg::score_val_t         bv_reg;
    logic [ST_W-1:0]             bs_reg;
    logic [ST_W-1:0]             cur_reg;
    logic [LEN_W-1:0]            tb_reg;

    logic                        out_valid_reg;
    logic                        kind_reg;
    logic [ST_W-1:0]             sidx_reg;
    hvd_pkg::score_val_t         score_reg;
    logic [LEN_W-1:0]            len_reg;
    logic [1:0]                  status_reg;

    logic [ST_W:0]               bp_mem [hvd_pkg::MAX_LEN][NS];
    logic [ST_W:0]               bp_rd_reg [NS];
    logic [ST_W-1:0]             path_mem [hvd_pkg::MAX_LEN];
    logic [ST_W-1:0]             path_rd_reg;

    hvd_pkg::carry_t             carry [NS];
    hvd_pkg::score_t             cell_score [NS];
    logic [ST_W:0]               cell_bp [NS];
    hvd_pkg::tbl_wr_t            wr;
    hvd_pkg::cell_ctl_t          ctl;

    logic [hvd_pkg::NST_W-1:0]   eff_st;
    logic [hvd_pkg::NSYM_W-1:0]  eff_sym;
    logic                        in_acc;
    logic                        out_acc;
    logic                        cfg_wr;
    logic [LEN_W-1:0]            tb_dec;
    hvd_pkg::score_t             scan_score;
    logic                        scan_ok;

    assign eff_st  = (nst_reg == '0) ? hvd_pkg::NST_W'(1)
                   : (nst_reg > hvd_pkg::NST_W'(NS)) ? hvd_pkg::NST_W'(NS) : nst_reg;
    assign eff_sym = (nsym_reg == '0) ? hvd_pkg::NSYM_W'(1)
                   : (nsym_reg > hvd_pkg::NSYM_W'(hvd_pkg::NUM_SYM))
                     ? hvd_pkg::NSYM_W'(hvd_pkg::NUM_SYM) : nsym_reg;

    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_acc     = out_valid_reg && out_ch.ready;
    assign cfg_wr      = psel && penable && pwrite;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == hvd_pkg::REG_NUM_SYMBOLS)
                       ? {26'd0, nsym_reg} : {27'd0, nst_reg};

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = kind_reg;
    assign out_ch.state_index = sidx_reg;
    assign out_ch.final_score = score_reg;
    assign out_ch.path_length = len_reg;
    assign out_ch.status      = status_reg;

    assign wr.vld        = in_acc;
    assign wr.func       = in_ch.func;
    assign wr.from_state = in_ch.from_state;
    assign wr.to_state   = in_ch.to_state;
    assign wr.symbol     = in_ch.symbol;
    assign wr.entry      = '{imp: in_ch.impossible, val: in_ch.log_value};

    assign ctl.load   = (state_reg == ST_LOAD);
    assign ctl.step   = (state_reg == ST_SCAN) && !cnt_reg[ST_W];
    assign ctl.finish = (state_reg == ST_FIN);
    assign ctl.t_zero = (time_reg == '0);
    assign ctl.sym_ok = {1'b0, sym_reg} < eff_sym;
    assign ctl.num_st = eff_st;
    assign ctl.symbol = sym_reg;
    // clear scores whenever a sequence closes
    assign ctl.clear  = (state_reg == ST_BEST && cnt_reg[ST_W-1:0] == ST_W'(NS - 1)
                         && !found_reg && !(scan_ok))
                      || (state_reg == ST_TB && tb_dec == '0)
                      || (in_acc && in_ch.func == hvd_pkg::FUNC_OBS
                          && time_reg >= LEN_W'(hvd_pkg::MAX_LEN) && in_ch.last);

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_cell
            hvd_acs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_id   (ST_W'(gi)),
                .wr        (wr),
                .ctl       (ctl),
                .carry_in  (carry[(gi + 1) % NS]),
                .carry_out (carry[gi]),
                .score     (cell_score[gi]),
                .back_ptr  (cell_bp[gi])
            );
        end
    endgenerate

    assign scan_score = cell_score[cnt_reg[ST_W-1:0]];
    assign scan_ok    = ({1'b0, cnt_reg[ST_W-1:0]} < eff_st) && !scan_score.imp
                        && (!found_reg || scan_score.val > bv_reg);
    assign tb_dec     = tb_reg - LEN_W'(1);

    // back-pointer rows: one row per time step after the first, lanes written for states in use
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && !ctl.t_zero)
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (ST_W'(s) < eff_st[ST_W-1:0] || eff_st[ST_W])
                    bp_mem[time_reg[POS_W-1:0]][s] <= cell_bp[s];
            end
        end
        if (state_reg == ST_TB)
            bp_rd_reg <= bp_mem[tb_dec[POS_W-1:0]];
        if (state_reg == ST_TB)
            path_mem[tb_dec[POS_W-1:0]] <= cur_reg;
        if (in_acc)
            path_rd_reg <= path_mem[in_ch.position];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            nst_reg        <= hvd_pkg::NST_W'(16);
            nsym_reg       <= hvd_pkg::NSYM_W'(32);
            time_reg       <= '0;
            path_ready_reg <= 1'b0;
            stored_len_reg <= '0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == hvd_pkg::REG_NUM_STATES)
                    nst_reg <= pwdata[hvd_pkg::NST_W-1:0];
                else
                    nsym_reg <= pwdata[hvd_pkg::NSYM_W-1:0];
            end
            if (out_acc)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && in_ch.func == hvd_pkg::FUNC_READ)
                    begin
                        if (!path_ready_reg || {1'b0, in_ch.position} >= stored_len_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= hvd_pkg::KIND_PATH;
                            sidx_reg      <= '0;
                            score_reg     <= '0;
                            len_reg       <= stored_len_reg;
                            status_reg    <= hvd_pkg::STAT_RANGE;
                        end
                        else
                            state_reg <= ST_RD;
                    end
                    else if (in_acc && in_ch.func == hvd_pkg::FUNC_OBS)
                    begin
                        sym_reg  <= in_ch.symbol;
                        last_reg <= in_ch.last;
                        if (time_reg >= LEN_W'(hvd_pkg::MAX_LEN))
                        begin
                            // drop the observation, flag an overlong sequence
                            if (in_ch.last)
                            begin
                                time_reg       <= '0;
                                path_ready_reg <= 1'b0;
                                out_valid_reg  <= 1'b1;
                                kind_reg       <= hvd_pkg::KIND_SUMMARY;
                                sidx_reg       <= '0;
                                score_reg      <= '0;
                                len_reg        <= LEN_W'(hvd_pkg::MAX_LEN);
                                status_reg     <= hvd_pkg::STAT_TOO_LONG;
                            end
                            else
                                time_reg <= LEN_W'(hvd_pkg::MAX_LEN + 1);
                        end
                        else
                            state_reg <= ST_LOAD;
                    end
                end
                ST_RD:
                begin
                    out_valid_reg <= 1'b1;
                    kind_reg      <= hvd_pkg::KIND_PATH;
                    sidx_reg      <= path_rd_reg;
                    score_reg     <= '0;
                    len_reg       <= stored_len_reg;
                    status_reg    <= hvd_pkg::STAT_OK;
                    state_reg     <= ST_IDLE;
                end
                ST_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // shift steps round the ring, then drain the compare stage
                    if (cnt_reg == (ST_W + 1)'(NS))
                        state_reg <= ST_FIN;
                    else
                        cnt_reg <= cnt_reg + (ST_W + 1)'(1);
                end
                ST_FIN:
                begin
                    time_reg  <= time_reg + LEN_W'(1);
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= last_reg ? ST_BEST : ST_IDLE;
                end
                ST_BEST:
                begin
                    if (scan_ok)
                    begin
                        found_reg <= 1'b1;
                        bv_reg    <= scan_score.val;
                        bs_reg    <= cnt_reg[ST_W-1:0];
                        cur_reg   <= cnt_reg[ST_W-1:0];
                    end
                    if (cnt_reg[ST_W-1:0] == ST_W'(NS - 1))
                    begin
                        if (found_reg || scan_ok)
                        begin
                            tb_reg    <= time_reg;
                            state_reg <= ST_TB;
                        end
                        else
                        begin
                            out_valid_reg  <= 1'b1;
                            kind_reg       <= hvd_pkg::KIND_SUMMARY;
                            sidx_reg       <= '0;
                            score_reg      <= '0;
                            len_reg        <= time_reg;
                            status_reg     <= hvd_pkg::STAT_NO_PATH;
                            path_ready_reg <= 1'b0;
                            time_reg       <= '0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + (ST_W + 1)'(1);
                end
                ST_TB:
                begin
                    tb_reg <= tb_dec;
                    if (tb_dec == '0)
                    begin
                        out_valid_reg  <= 1'b1;
                        kind_reg       <= hvd_pkg::KIND_SUMMARY;
                        sidx_reg       <= bs_reg;
                        score_reg      <= bv_reg;
                        len_reg        <= time_reg;
                        status_reg     <= hvd_pkg::STAT_OK;
                        path_ready_reg <= 1'b1;
                        stored_len_reg <= time_reg;
                        time_reg       <= '0;
                        state_reg      <= ST_IDLE;
                    end
                    else
                        state_reg <= ST_TBSEL;
                end
                ST_TBSEL:
                begin
                    // follow the pointer; an invalid one leads to state 0
                    cur_reg   <= bp_rd_reg[cur_reg][ST_W] ? bp_rd_reg[cur_reg][ST_W-1:0] : '0;
                    state_reg <= ST_TB;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: design/hvd_checker.sv
`timescale 1ns / 1ps
module hvd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               kind,
    input logic signed [hvd_pkg::SCORE_W-1:0] final_score,
    input logic [hvd_pkg::LEN_W-1:0]          path_length,
    input logic [1:0]                         status,
    input logic                               pready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_no_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result waits");

    a_path_score_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == hvd_pkg::KIND_PATH |-> final_score == '0)
        else $error("path entry with nonzero score");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == hvd_pkg::KIND_SUMMARY && status == hvd_pkg::STAT_OK
        |-> path_length != '0)
        else $error("decoded sequence of length zero");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind hmm_viterbi_decoder hvd_checker u_hvd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .kind        (out_ch.kind),
    .final_score (out_ch.final_score),
    .path_length (out_ch.path_length),
    .status      (out_ch.status),
    .pready      (pready)
);
